[hw/rtl/gnorm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnorm_pkg
// shared types and constants of the upwind gradient norm pipeline
// ---------------------------------------------------------------------------
package gnorm_pkg;

    localparam int OUT_WIDTH = 16;

    typedef logic [OUT_WIDTH-1:0] t_norm;

    localparam t_norm OUT_MAX = '1;

endpackage

[hw/rtl/gnorm_upwind.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnorm_upwind
// three-stage front end: upwind selection per axis, squaring, sum of squares
// ---------------------------------------------------------------------------
module gnorm_upwind #(
    parameter int W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [W-1:0]      i_back_dx,
    input  logic [W-1:0]      i_fwd_dx,
    input  logic [W-1:0]      i_back_dy,
    input  logic [W-1:0]      i_fwd_dy,
    input  logic              i_level_negative,
    output logic              o_valid,
    output logic [2*W-1:0]    o_sum
);
    import gnorm_pkg::*;

    localparam int XW = 2 * W;
    localparam logic [XW-1:0] MAX_SQ = XW'(1) << (2 * W - 2);

    function automatic logic [W-1:0] f_pos(input logic [W-1:0] v);
        return v[W-1] ? '0 : v;
    endfunction

    function automatic logic [W-1:0] f_neg(input logic [W-1:0] v);
        return v[W-1] ? W'(~v + W'(1)) : '0;
    endfunction

    function automatic logic [W-1:0] f_max(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [W-1:0]  n_mag_x, n_mag_y;
    logic [W-1:0]  r_mag_x, r_mag_y;
    logic [XW-1:0] r_sq_x, r_sq_y;
    logic [XW-1:0] r_sum;
    logic          r_v1, r_v2, r_v3;

    // larger magnitude gives the larger square
    always_comb begin
        if (!i_level_negative) begin
            n_mag_x = f_max(f_pos(i_back_dx), f_neg(i_fwd_dx));
            n_mag_y = f_max(f_pos(i_back_dy), f_neg(i_fwd_dy));
        end else begin
            n_mag_x = f_max(f_neg(i_back_dx), f_pos(i_fwd_dx));
            n_mag_y = f_max(f_neg(i_back_dy), f_pos(i_fwd_dy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag_x <= n_mag_x;
            r_mag_y <= n_mag_y;
            r_sq_x  <= XW'(r_mag_x) * XW'(r_mag_x);
            r_sq_y  <= XW'(r_mag_y) * XW'(r_mag_y);
            r_sum   <= r_sq_x + r_sq_y;
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;

    a_square_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_sq_x <= MAX_SQ) && (r_sq_y <= MAX_SQ))
        else $error("axis square out of range");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_sum <= (MAX_SQ << 1))
        else $error("sum of squares out of range");

endmodule

[hw/rtl/gnorm_sqrt.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnorm_sqrt
// pipelined restoring integer square root, one result bit per stage,
// truncated and saturated to the output width
// ---------------------------------------------------------------------------
module gnorm_sqrt #(
    parameter int W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [2*W-1:0]    i_sum,
    output logic              o_valid,
    output gnorm_pkg::t_norm  o_root
);
    import gnorm_pkg::*;

    localparam int XW = 2 * W;

    logic [XW-1:0] r_x   [W];
    logic [XW-1:0] r_res [W];
    logic          r_v   [W];

    for (genvar j = 0; j < W; j++) begin : g_stage
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (W - 1 - j));
        logic [XW-1:0] x_in, res_in, trial, n_x, n_res;
        logic          v_in;

        if (j == 0) begin : g_first
            assign x_in   = i_sum;
            assign res_in = '0;
            assign v_in   = i_valid;
        end else begin : g_next
            assign x_in   = r_x[j-1];
            assign res_in = r_res[j-1];
            assign v_in   = r_v[j-1];
        end

        assign trial = res_in + BIT;

        always_comb begin
            if (x_in >= trial) begin
                n_x   = x_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_adv) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[j]   <= n_x;
                r_res[j] <= n_res;
            end
        end
    end

    logic [W-1:0] w_root;
    assign w_root = r_res[W-1][W-1:0];

    if (W > OUT_WIDTH) begin : g_sat
        assign o_root = (|w_root[W-1:OUT_WIDTH]) ? OUT_MAX : w_root[OUT_WIDTH-1:0];
    end else begin : g_ext
        assign o_root = t_norm'(w_root);
    end

    assign o_valid = r_v[W-1];

    // remainder of a truncated root never exceeds twice the root
    a_root_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[W-1] |-> r_x[W-1] <= (r_res[W-1] << 1))
        else $error("square root remainder too large");

endmodule

[hw/rtl/godunov_gradient_norm_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// godunov_gradient_norm_top
// upwind gradient magnitude of one 2-d level-set grid point per request
//
//   channel   direction  handshake             payload
//   input     in         i_valid / o_stall     back_dx fwd_dx back_dy fwd_dy level_negative
//   output    out        o_valid / i_stall     gradient_norm
//
// one request per cycle while the output is not stalled; the pipeline is
// three front-end stages, one root stage per result bit and the output register
// all stages move together; a held output stalls the whole pipeline
// reset clears the valid bits only, no clearing pass
// ---------------------------------------------------------------------------
module godunov_gradient_norm_top #(
    parameter int DERIV_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [DERIV_WIDTH-1:0] i_back_dx,
    input  logic [DERIV_WIDTH-1:0] i_fwd_dx,
    input  logic [DERIV_WIDTH-1:0] i_back_dy,
    input  logic [DERIV_WIDTH-1:0] i_fwd_dy,
    input  logic                   i_level_negative,
    output logic                   o_valid,
    input  logic                   i_stall,
    output gnorm_pkg::t_norm       o_gradient_norm
);
    import gnorm_pkg::*;

    logic                     w_adv;
    logic                     w_sum_valid;
    logic [2*DERIV_WIDTH-1:0] w_sum;
    logic                     w_root_valid;
    t_norm                    w_root;
    logic                     r_out_valid;
    t_norm                    r_norm;

    assign w_adv = !(r_out_valid && i_stall);

    gnorm_upwind #(
        .W (DERIV_WIDTH)
    ) u_upwind (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_valid          (i_valid),
        .i_back_dx        (i_back_dx),
        .i_fwd_dx         (i_fwd_dx),
        .i_back_dy        (i_back_dy),
        .i_fwd_dy         (i_fwd_dy),
        .i_level_negative (i_level_negative),
        .o_valid          (w_sum_valid),
        .o_sum            (w_sum)
    );

    gnorm_sqrt #(
        .W (DERIV_WIDTH)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .o_valid (w_root_valid),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_root_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_norm <= w_root;
        end
    end

    assign o_stall         = !w_adv;
    assign o_valid         = r_out_valid;
    assign o_gradient_norm = r_norm;

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("stall raised with empty output register");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_sum_valid) && $stable(w_root_valid))
        else $error("pipeline moved during stall");

endmodule
